// ===== hw/rtl/ticker_hourly_trade_aggregator_defines.svh =====
// ----------------------------------------------------------------------------
// Ticker hourly trade aggregator: assertion macros
// Shared concurrent check forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TICKER_HOURLY_TRADE_AGGREGATOR_DEFINES_SVH
`define TICKER_HOURLY_TRADE_AGGREGATOR_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define HTA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hta_pkg.sv =====
// ----------------------------------------------------------------------------
// Ticker hourly trade aggregator package
// Sizes, status codes and the transaction and token types of the block.
// ----------------------------------------------------------------------------
package hta_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BYTES     = 8;
	localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

	localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
		((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	typedef enum logic [1:0] {
		ST_NEW  = 2'd0,
		ST_ROLL = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [63:0] ticker_key;
		logic [4:0]  trade_hour;
		logic [15:0] trade_price;
		logic [15:0] trade_qty;
	} trade_t;

	typedef struct packed {
		logic [63:0] out_key;
		logic [4:0]  out_hour;
		logic [15:0] out_qty;
		logic [15:0] out_first_price;
		logic [15:0] out_last_price;
		status_t     out_status;
	} result_t;

	// Trade walking down the cell row, with the entry picked up on the way.
	typedef struct packed {
		logic        valid;
		logic        found;
		logic        inserted;
		logic        rise;
		logic [63:0] key;
		logic [4:0]  hour;
		logic [15:0] price;
		logic [15:0] qty;
		logic [4:0]  e_hour;
		logic [15:0] e_qty;
		logic [15:0] e_first;
		logic [15:0] e_last;
	} token_t;

endpackage

// ===== hw/rtl/ticker_hourly_trade_aggregator.sv =====
// ----------------------------------------------------------------------------
// Ticker hourly trade aggregator
// Per-ticker quantity and price tracking over a row of table cells.
// ----------------------------------------------------------------------------
// A trade is taken on any cycle with start high; busy stays low, so one trade
// can be issued every cycle. Each trade walks the row of TABLE_ENTRIES cells
// one cell per cycle, updating or filling its entry as it passes, and its
// result (if any) is registered at the end of the row and shown on result
// with done high for one cycle. Results come out in trade order and cannot
// be held off: capture them on the cycle done is high. A hit without a later
// hour gives no result.
module ticker_hourly_trade_aggregator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  hta_pkg::trade_t  trade,
	output logic             done,
	output hta_pkg::result_t result
);

	`include "ticker_hourly_trade_aggregator_defines.svh"

	localparam int N = hta_pkg::TABLE_ENTRIES;

	hta_pkg::token_t tok [0:N];
	hta_pkg::token_t tok_in_q;
	hta_pkg::token_t tok_ld;
	hta_pkg::token_t tok_head;
	logic            tok_vld_q;
	logic [N-1:0]    occupied;
	logic [N-1:0]    is_next;
	logic [N-1:0]    ins_vec;
	logic [hta_pkg::USED_W-1:0] used_q;
	hta_pkg::token_t tail;
	logic            emit;
	logic            done_q;
	hta_pkg::result_t result_q;

	assign busy = 1'b0;

	// Launch an accepted trade as a token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= start && !busy;
		end
	end

	always_comb begin
		tok_ld       = '0;
		tok_ld.key   = trade.ticker_key & hta_pkg::KEY_MASK;
		tok_ld.hour  = trade.trade_hour;
		tok_ld.price = trade.trade_price;
		tok_ld.qty   = trade.trade_qty;
	end

	always_ff @(posedge clk) begin
		tok_in_q <= tok_ld;
	end

	always_comb begin
		tok_head       = tok_in_q;
		tok_head.valid = tok_vld_q;
	end

	assign tok[0] = tok_head;

	// Decode the fill count and build the cell row
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign occupied[i] = hta_pkg::USED_W'(i) < used_q;
		assign is_next[i]  = hta_pkg::USED_W'(i) == used_q;

		hta_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.occupied (occupied[i]),
			.is_next  (is_next[i]),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1]),
			.insert   (ins_vec[i])
		);
	end

	// Count filled entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (|ins_vec) begin
			used_q <= used_q + 1'b1;
		end
	end

	// Form the result at the end of the row
	assign tail = tok[N];
	assign emit = tail.valid && (!tail.found || tail.inserted || tail.rise);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_key         <= tail.key;
		result_q.out_hour        <= tail.e_hour;
		result_q.out_qty         <= tail.e_qty;
		result_q.out_first_price <= tail.e_first;
		result_q.out_last_price  <= tail.e_last;
		priority if (tail.inserted) begin
			result_q.out_status <= hta_pkg::ST_NEW;
		end else if (tail.found) begin
			result_q.out_status <= hta_pkg::ST_ROLL;
		end else begin
			result_q.out_status <= hta_pkg::ST_FULL;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks on fill count, insertion and dropped transactions
	`HTA_ASSERT_SAME(a_used_bound, 1'b1, used_q <= hta_pkg::USED_W'(N), "fill count overflow")
	`HTA_ASSERT_SAME(a_one_insert, 1'b1, $onehot0(ins_vec), "two cells filled in one cycle")
	`HTA_ASSERT_NEXT(a_used_step, |ins_vec, used_q == $past(used_q) + 1'b1, "fill count missed insert")
	`HTA_ASSERT_SAME(a_miss_full, tail.valid && !tail.found, used_q == hta_pkg::USED_W'(N), "drop while table not full")
	`HTA_ASSERT_SAME(a_drop_zero, done && result.out_status == hta_pkg::ST_FULL, result.out_qty == 16'd0 && result.out_hour == 5'd0, "dropped transaction carries entry data")

endmodule

// ===== hw/rtl/hta_cell.sv =====
// ----------------------------------------------------------------------------
// Ticker hourly trade aggregator: table cell
// Holds one ticker entry; updates or fills it as a trade token passes and
// hands the token to the next cell through a register.
// ----------------------------------------------------------------------------
module hta_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            occupied,
	input  logic            is_next,
	input  hta_pkg::token_t tok_in,
	output hta_pkg::token_t tok_out,
	output logic            insert
);

	logic [63:0] key_q;
	logic [4:0]  hour_q;
	logic [15:0] qty_q;
	logic [15:0] first_q;
	logic [15:0] last_q;

	logic        hit;
	logic        rise;
	logic [15:0] qty_sum;
	hta_pkg::token_t tok_nx;
	hta_pkg::token_t tok_q;
	logic        tok_vld_q;

	// Match against the stored key; fill only the first free entry on a miss
	assign hit     = tok_in.valid && occupied && (key_q == tok_in.key);
	assign insert  = tok_in.valid && is_next && !tok_in.found;
	assign rise    = tok_in.hour > hour_q;
	assign qty_sum = qty_q + tok_in.qty;

	// Build the token handed to the neighbor
	always_comb begin
		tok_nx = tok_in;
		if (hit) begin
			tok_nx.found   = 1'b1;
			tok_nx.rise    = rise;
			tok_nx.e_hour  = tok_in.hour;
			tok_nx.e_qty   = qty_sum;
			tok_nx.e_first = first_q;
			tok_nx.e_last  = tok_in.price;
		end else if (insert) begin
			tok_nx.found    = 1'b1;
			tok_nx.inserted = 1'b1;
			tok_nx.e_hour   = tok_in.hour;
			tok_nx.e_qty    = tok_in.qty;
			tok_nx.e_first  = tok_in.price;
			tok_nx.e_last   = tok_in.price;
		end
	end

	// Update the entry
	always_ff @(posedge clk) begin
		if (hit) begin
			hour_q <= tok_in.hour;
			qty_q  <= qty_sum;
			last_q <= tok_in.price;
		end else if (insert) begin
			key_q   <= tok_in.key;
			hour_q  <= tok_in.hour;
			qty_q   <= tok_in.qty;
			first_q <= tok_in.price;
			last_q  <= tok_in.price;
		end
	end

	// Advance the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_nx.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nx;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_vld_q;
	end

endmodule
